@@ src/aes_pkg.sv @@
package aes_pkg;

   typedef logic [127:0] block_type;

   localparam logic CSR_KEY_HI = 1'b0;
   localparam logic CSR_KEY_LO = 1'b1;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // byte i sits at bits [127-8i -: 8]
   function automatic logic [7:0] get_byte(block_type v, int i);
      return v[127 - 8*i -: 8];
   endfunction

   function automatic logic [7:0] xtime(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic block_type next_key(block_type k, logic [7:0] rc);
      block_type n;
      logic [31:0] t;
      t = {SBOX[get_byte(k, 13)] ^ rc, SBOX[get_byte(k, 14)],
           SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
      n[127:96] = k[127:96] ^ t;
      n[95:64]  = k[95:64] ^ n[127:96];
      n[63:32]  = k[63:32] ^ n[95:64];
      n[31:0]   = k[31:0] ^ n[63:32];
      return n;
   endfunction

   // SubBytes, ShiftRows, optional MixColumns, AddRoundKey
   function automatic block_type enc_round(block_type s, block_type k, logic mix);
      block_type t;
      block_type m;
      logic [7:0] a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(c*4 + r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
         end
      end
      m = t;
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = get_byte(t, 4*c);
            a1 = get_byte(t, 4*c + 1);
            a2 = get_byte(t, 4*c + 2);
            a3 = get_byte(t, 4*c + 3);
            all = a0 ^ a1 ^ a2 ^ a3;
            m[127 - 8*(4*c) -: 8]     = a0 ^ all ^ xtime(a0 ^ a1);
            m[127 - 8*(4*c + 1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            m[127 - 8*(4*c + 2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            m[127 - 8*(4*c + 3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
      return m ^ k;
   endfunction

endpackage

@@ src/aes128_block_encrypt_unit.sv @@
// channel | ports                                  | direction
// req     | req_valid/ready, req_plaintext_hi/lo   | plaintext item in
// rsp     | rsp_valid/ready, rsp_ciphertext_hi/lo  | ciphertext item out
// csr     | csr_valid/ready, csr_index, csr_data   | key write (0 = hi, 1 = lo)
// One stage for the initial AddRoundKey, then one stage per round; one item per cycle
// while rsp is not stalled. The round key travels with each item.
// Reset clears the key and all valid bits. A stall at rsp freezes the whole
// pipeline (common enable); req_ready is high whenever the last stage can move.
module aes128_block_encrypt_unit import aes_pkg::*; #(
   parameter int ROUNDS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_plaintext_hi,
   input  logic [63:0] req_plaintext_lo,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_ciphertext_hi,
   output logic [63:0] rsp_ciphertext_lo,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);

   logic [63:0] key_hi_ff, key_lo_ff;
   logic        vld_ff [ROUNDS+1];
   block_type   st_ff  [ROUNDS+1];
   block_type   rk_ff  [ROUNDS+1];
   logic [7:0]  rc_ff  [ROUNDS+1];
   logic        adv;

   assign adv       = !vld_ff[ROUNDS] || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_KEY_HI: key_hi_ff <= csr_data;
            CSR_KEY_LO: key_lo_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= ROUNDS; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i <= ROUNDS; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= {req_plaintext_hi, req_plaintext_lo} ^ {key_hi_ff, key_lo_ff};
         rk_ff[0] <= {key_hi_ff, key_lo_ff};
         rc_ff[0] <= 8'h01;
         for (int i = 1; i <= ROUNDS; i++) begin
            rk_ff[i] <= next_key(rk_ff[i-1], rc_ff[i-1]);
            rc_ff[i] <= xtime(rc_ff[i-1]);
            st_ff[i] <= enc_round(st_ff[i-1], next_key(rk_ff[i-1], rc_ff[i-1]),
                                  i != ROUNDS);
         end
      end
   end

   assign rsp_valid         = vld_ff[ROUNDS];
   assign rsp_ciphertext_hi = st_ff[ROUNDS][127:64];
   assign rsp_ciphertext_lo = st_ff[ROUNDS][63:0];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ciphertext_hi))
      else $error("result changed while stalled");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted item lost");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("ready low with empty output");

endmodule

@@ test/aes128_block_encrypt_unit_tb.sv @@
`timescale 1ns / 100ps

module aes128_block_encrypt_unit_tb;
   import aes_pkg::*;

   localparam int NUM_ROUNDS = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = NUM_ROUNDS + 20;
   localparam logic [7:0] AFFINE_C = 8'h63;
   localparam logic [7:0] POLY_LOW = 8'h1b;

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
   } half_pair_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [63:0] req_plaintext_hi;
   logic [63:0] req_plaintext_lo;
   logic rsp_valid;
   logic rsp_ready;
   logic [63:0] rsp_ciphertext_hi;
   logic [63:0] rsp_ciphertext_lo;
   logic csr_valid;
   logic csr_ready;
   logic csr_index;
   logic [63:0] csr_data;

   half_pair_type plaintext_pending[$];
   half_pair_type ciphertext_due[$];
   logic [7:0] sub_table[256];
   block_type key_shadow;
   logic req_taken;
   logic quiet;
   int req_gap;
   int rsp_stall;
   int mismatches;
   int checked;
   int cycles;
   int key_changes;

   aes128_block_encrypt_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_plaintext_hi(req_plaintext_hi), .req_plaintext_lo(req_plaintext_lo),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_ciphertext_hi(rsp_ciphertext_hi), .rsp_ciphertext_lo(rsp_ciphertext_lo),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   function automatic logic [7:0] gf_double(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? POLY_LOW : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ a;
         a = gf_double(a);
      end
      return p;
   endfunction

   // S-box from the field inverse (a^254) and the affine map
   function automatic void build_sub_table();
      logic [7:0] inv;
      logic [7:0] sq;
      for (int v = 0; v < 256; v++) begin
         inv = 8'h01;
         sq = v[7:0];
         for (int e = 0; e < 8; e++) begin
            if (e != 0) inv = gf_mul(inv, sq);
            sq = gf_mul(sq, sq);
         end
         sub_table[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ AFFINE_C;
      end
   endfunction

   function automatic half_pair_type encrypt_block(block_type pt, block_type key);
      logic [7:0] st[16];
      logic [7:0] tmp[16];
      logic [7:0] rk[16];
      logic [7:0] w[4];
      logic [7:0] rc;
      logic [7:0] a0, a1, a2, a3, all;
      block_type res;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) begin
         rk[i] = key[127 - 8*i -: 8];
         st[i] = pt[127 - 8*i -: 8] ^ rk[i];
      end
      for (int r = 1; r <= NUM_ROUNDS; r++) begin
         w[0] = sub_table[rk[13]] ^ rc;
         w[1] = sub_table[rk[14]];
         w[2] = sub_table[rk[15]];
         w[3] = sub_table[rk[12]];
         for (int i = 0; i < 4; i++) rk[i] = rk[i] ^ w[i];
         for (int i = 4; i < 16; i++) rk[i] = rk[i] ^ rk[i-4];
         rc = gf_double(rc);
         // index = column*4 + row; row r shifts left by r columns
         for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
               tmp[c*4 + j] = sub_table[st[((c + j) % 4)*4 + j]];
         if (r < NUM_ROUNDS) begin
            for (int c = 0; c < 4; c++) begin
               a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
               all = a0 ^ a1 ^ a2 ^ a3;
               tmp[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
               tmp[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
               tmp[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
               tmp[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[i];
      end
      for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
      return res;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycles,
                  ciphertext_due.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // plaintext driver
   always @(negedge clock) begin
      logic nv;
      half_pair_type nxt;
      if (!reset && (!req_valid || req_taken)) begin
         nv = 1'b0;
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
         end else if (plaintext_pending.size() > 0) begin
            nxt = plaintext_pending.pop_front();
            nv = 1'b1;
            req_plaintext_hi <= nxt.hi;
            req_plaintext_lo <= nxt.lo;
            if (!quiet && $urandom_range(0, 9) == 0) req_gap <= $urandom_range(1, 19);
         end
         req_valid <= nv;
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            rsp_stall <= $urandom_range(0, 18);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // acceptance and checking
   always @(posedge clock) begin
      half_pair_type got;
      half_pair_type want;
      req_taken <= req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         ciphertext_due.push_back(encrypt_block({req_plaintext_hi, req_plaintext_lo},
                                                key_shadow));
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_ciphertext_hi, rsp_ciphertext_lo};
         if (ciphertext_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected ciphertext %h", got);
         end else begin
            want = ciphertext_due.pop_front();
            checked++;
            if (got.hi !== want.hi || got.lo !== want.lo) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ciphertext mismatch: expected %h_%h got %h_%h",
                           want.hi, want.lo, got.hi, got.lo);
            end
         end
      end
   end

   task automatic write_key_half(logic idx, logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_KEY_HI) key_shadow[127:64] = value;
      else key_shadow[63:0] = value;
      key_changes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_key(logic [63:0] hi, logic [63:0] lo);
      write_key_half(CSR_KEY_HI, hi);
      write_key_half(CSR_KEY_LO, lo);
   endtask

   task automatic queue_plaintext(logic [63:0] hi, logic [63:0] lo);
      half_pair_type p;
      p.hi = hi;
      p.lo = lo;
      plaintext_pending.push_back(p);
   endtask

   // hold the sender until the pipeline has fully emptied
   task automatic drain();
      while (plaintext_pending.size() > 0 || req_valid || ciphertext_due.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random(int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 7))
            0: queue_plaintext(64'h0, rand64());
            1: queue_plaintext(rand64(), '1);
            default: queue_plaintext(rand64(), rand64());
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_plaintext_hi = '0;
      req_plaintext_lo = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_KEY_HI;
      csr_data = '0;
      req_taken = 1'b0;
      quiet = 1'b0;
      req_gap = 0;
      rsp_stall = 0;
      mismatches = 0;
      checked = 0;
      cycles = 0;
      key_changes = 0;
      key_shadow = '0;
      build_sub_table();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // key left at its reset value
      queue_plaintext(64'h0, 64'h0);
      queue_plaintext('1, '1);
      queue_plaintext(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      queue_plaintext(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
      drain();

      // standard test key, with its published vector among the items
      load_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
      queue_plaintext(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
      queue_plaintext(64'h0, 64'h0);
      queue_plaintext('1, '1);
      queue_plaintext(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
      drain();

      load_key('1, '1);
      queue_plaintext(64'h0, 64'h0);
      queue_plaintext('1, '1);
      queue_plaintext(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
      drain();

      load_key(64'h8000_0000_0000_0000, 64'h0);
      queue_plaintext(64'h0, 64'h0);
      queue_plaintext(64'h0, 64'h1);
      drain();

      for (int ph = 0; ph < 14; ph++) begin
         load_key(rand64(), rand64());
         queue_random(100);
         drain();
      end

      quiet = 1'b1;
      load_key(rand64(), rand64());
      queue_random(100);
      drain();

      $display("%0d ciphertext items checked across %0d key register writes",
               checked, key_changes);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
